@@ src/rec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rec_pkg: shared types and constants of the roller eject controller
// Request and result payloads, per-roller state entry, configuration set,
// phase and command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package rec_pkg;

  localparam int unsigned NUM_ROLLERS_DEF = 15;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LOCATION_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_TIME_MIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_INTERVAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_LENGTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROLLER_LENGTH   = 3'd5;

  // Register reset values.
  localparam logic [7:0]  RST_LOCATION_WINDOW = 8'd5;
  localparam logic [15:0] RST_RUN_TIME_MIN    = 16'd500;
  localparam logic [9:0]  RST_RETRY_LIMIT     = 10'd400;
  localparam logic [15:0] RST_RETRY_INTERVAL  = 16'd50;
  localparam logic [15:0] RST_HEAD_LENGTH     = 16'd0;
  localparam logic [15:0] RST_ROLLER_LENGTH   = 16'd0;

  // Roller phases.
  localparam logic [1:0] PH_CHECK = 2'd0;
  localparam logic [1:0] PH_THROW = 2'd1;
  localparam logic [1:0] PH_JUDGE = 2'd2;
  localparam logic [1:0] PH_BACK  = 2'd3;

  // Drive commands.
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_FWD  = 2'd1;
  localparam logic [1:0] CMD_BACK = 2'd2;

  // Ejection outcomes.
  localparam logic [1:0] OUT_NONE    = 2'd0;
  localparam logic [1:0] OUT_EJECTED = 2'd1;
  localparam logic [1:0] OUT_NO_ROT  = 2'd2;

  localparam logic [9:0] ATTEMPT_MAX = 10'd1023;

  // Bit position of the not-returned flag of roller r is r + RET_BIT_OFS.
  localparam logic [4:0] RET_BIT_OFS = 5'd15;

  localparam int unsigned BASE_W = 34;
  localparam int unsigned LEAD_W = 14;

  typedef struct packed {
    logic [3:0]  roller;
    logic        has_package;
    logic [31:0] target_grid;
    logic [7:0]  direction;
    logic [31:0] trolley_pos;
    logic [15:0] trolley_speed;
    logic        at_home;
    logic [31:0] now_ms;
  } rec_in_t;

  typedef struct packed {
    logic [1:0]  drive_cmd;
    logic [3:0]  drive_roller;
    logic [7:0]  drive_direction;
    logic [1:0]  outcome;
    logic [30:0] alarm_word;
    logic [1:0]  phase_now;
  } rec_out_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [9:0]  attempts;
    logic [31:0] run_stamp;
    logic [31:0] send_stamp;
  } roll_st_t;

  typedef struct packed {
    logic [7:0]  location_window;
    logic [15:0] run_time_min;
    logic [9:0]  retry_limit;
    logic [15:0] retry_interval;
    logic [15:0] head_length;
    logic [15:0] roller_length;
  } rec_cfg_t;

endpackage

@@ src/rec_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rec_step: one control step of one roller
// Finishes the target correction, runs the phase decision and produces the
// next state entry, the next alarm word and the result of the request.
// ----------------------------------------------------------------------------
module rec_step #(
  parameter int unsigned NUM_ROLLERS = rec_pkg::NUM_ROLLERS_DEF
) (
  input  rec_pkg::rec_in_t              item_i,
  input  logic [rec_pkg::BASE_W-1:0]    base_i,
  input  logic [rec_pkg::LEAD_W-1:0]    lead_i,
  input  rec_pkg::roll_st_t             st_i,
  input  logic [30:0]                   alarm_i,
  input  rec_pkg::rec_cfg_t             cfg_i,
  output logic                          roller_ok_o,
  output rec_pkg::roll_st_t             st_o,
  output logic [30:0]                   alarm_o,
  output rec_pkg::rec_out_t             res_o
);
  import rec_pkg::*;

  logic [BASE_W-1:0] diff;
  logic [31:0]       target;
  logic [32:0]       target_hi;
  logic              in_window;
  logic [31:0]       run_elapsed;
  logic [31:0]       send_elapsed;
  logic [4:0]        nr_pos;
  logic [4:0]        ret_pos;
  logic [30:0]       nr_bit;
  logic [30:0]       ret_bit;
  logic [1:0]        cmd;
  logic [1:0]        outcome;

  assign roller_ok_o = (item_i.roller != 4'd0) &&
                       ({28'd0, item_i.roller} <= 32'(NUM_ROLLERS));

  // Corrected target saturates at zero and at the top of the 32-bit range.
  assign diff = base_i - BASE_W'(lead_i);
  always_comb begin
    if (base_i <= BASE_W'(lead_i)) begin
      target = '0;
    end else if (diff[BASE_W-1:32] != '0) begin
      target = '1;
    end else begin
      target = diff[31:0];
    end
  end

  assign target_hi = {1'b0, target} + 33'(cfg_i.location_window);
  assign in_window = (item_i.trolley_pos >= target) &&
                     ({1'b0, item_i.trolley_pos} <= target_hi);

  assign run_elapsed  = item_i.now_ms - st_i.run_stamp;
  assign send_elapsed = item_i.now_ms - st_i.send_stamp;

  assign nr_pos  = {1'b0, item_i.roller} - 5'd1;
  assign ret_pos = {1'b0, item_i.roller} + RET_BIT_OFS;
  assign nr_bit  = 31'(1) << nr_pos;
  assign ret_bit = 31'(1) << ret_pos;

  always_comb begin
    st_o    = st_i;
    alarm_o = alarm_i;
    cmd     = CMD_NONE;
    outcome = OUT_NONE;
    case (st_i.phase)
      PH_CHECK: begin
        if (item_i.has_package) begin
          if (in_window) begin
            st_o.phase = PH_THROW;
          end
        end else if (!item_i.at_home) begin
          st_o.attempts = '0;
          st_o.phase    = PH_BACK;
        end
      end
      PH_THROW: begin
        cmd             = CMD_FWD;
        st_o.run_stamp  = item_i.now_ms;
        st_o.phase      = PH_JUDGE;
      end
      PH_JUDGE: begin
        if (run_elapsed >= {16'd0, cfg_i.run_time_min}) begin
          if (item_i.at_home) begin
            outcome    = OUT_NO_ROT;
            alarm_o    = alarm_i | nr_bit;
            st_o.phase = PH_CHECK;
          end else begin
            outcome    = OUT_EJECTED;
            alarm_o    = alarm_i & ~nr_bit;
            st_o.phase = PH_BACK;
          end
        end
      end
      PH_BACK: begin
        if (item_i.at_home) begin
          st_o.phase    = PH_CHECK;
          st_o.attempts = '0;
          alarm_o       = alarm_i & ~ret_bit;
        end else if (send_elapsed >= {16'd0, cfg_i.retry_interval}) begin
          st_o.send_stamp = item_i.now_ms;
          if (st_i.attempts < cfg_i.retry_limit) begin
            cmd = CMD_BACK;
          end else begin
            alarm_o = alarm_i | ret_bit;
          end
          if (st_i.attempts != ATTEMPT_MAX) begin
            st_o.attempts = st_i.attempts + 10'd1;
          end
        end
      end
      default: begin
        st_o = st_i;
      end
    endcase
  end

  always_comb begin
    if (roller_ok_o) begin
      res_o.drive_cmd       = cmd;
      res_o.drive_roller    = (cmd != CMD_NONE) ? item_i.roller : 4'd0;
      res_o.drive_direction = (cmd != CMD_NONE) ? item_i.direction : 8'd0;
      res_o.outcome         = outcome;
      res_o.alarm_word      = alarm_o;
      res_o.phase_now       = st_o.phase;
    end else begin
      res_o.drive_cmd       = CMD_NONE;
      res_o.drive_roller    = 4'd0;
      res_o.drive_direction = 8'd0;
      res_o.outcome         = OUT_NONE;
      res_o.alarm_word      = alarm_i;
      res_o.phase_now       = PH_CHECK;
    end
  end

endmodule

@@ src/roller_eject_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roller_eject_controller: per-roller ejection sequencer of a sort trolley
// Corrects each request's target for roller position and trolley speed,
// steps the roller through check, throw, judge and back, issues drive
// commands and keeps the shared alarm word.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle while the result side does not stall:
// the accepting edge registers the request together with the uncorrected
// target sum and the speed lead, and the edge that moves it on to the result
// register reads the roller's state entry, decides the step and writes the
// entry and the result register at the same time, so a request for the same
// roller in the next cycle already sees the updated state. The rate rests on
// the state table read-modify-write happening within that step. Configuration
// registers are written through their own port, which is always ready.
module roller_eject_controller #(
  parameter int unsigned NUM_ROLLERS = rec_pkg::NUM_ROLLERS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  rec_pkg::rec_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output rec_pkg::rec_out_t                  out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rec_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rec_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import rec_pkg::*;

  localparam int unsigned IdxW = (NUM_ROLLERS > 1) ? $clog2(NUM_ROLLERS) : 1;

  rec_cfg_t          cfg_q;
  roll_st_t          st_q [NUM_ROLLERS];
  logic [30:0]       alarm_q;

  logic              s1_valid_q;
  rec_in_t           s1_item_q;
  logic [BASE_W-1:0] s1_base_q;
  logic [LEAD_W-1:0] s1_lead_q;

  logic              out_valid_q;
  rec_out_t          out_q;

  logic              in_accept;
  logic              s1_fire;
  logic [BASE_W-1:0] base_d;
  logic [LEAD_W-1:0] lead_d;
  logic [16:0]       speed_up;
  logic [19:0]       pitch_ofs;
  logic [4:0]        idx_full;
  logic [IdxW-1:0]   rd_idx;
  roll_st_t          st_rd;
  roll_st_t          st_d;
  logic [30:0]       alarm_d;
  rec_out_t          res_d;
  logic              roller_ok;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.location_window <= RST_LOCATION_WINDOW;
      cfg_q.run_time_min    <= RST_RUN_TIME_MIN;
      cfg_q.retry_limit     <= RST_RETRY_LIMIT;
      cfg_q.retry_interval  <= RST_RETRY_INTERVAL;
      cfg_q.head_length     <= RST_HEAD_LENGTH;
      cfg_q.roller_length   <= RST_ROLLER_LENGTH;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_LOCATION_WINDOW: cfg_q.location_window <= cfg_data_i[7:0];
        REG_RUN_TIME_MIN:    cfg_q.run_time_min    <= cfg_data_i;
        REG_RETRY_LIMIT:     cfg_q.retry_limit     <= cfg_data_i[9:0];
        REG_RETRY_INTERVAL:  cfg_q.retry_interval  <= cfg_data_i;
        REG_HEAD_LENGTH:     cfg_q.head_length     <= cfg_data_i;
        REG_ROLLER_LENGTH:   cfg_q.roller_length   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // ---------------- input stage ----------------
  // The uncorrected sum needs 33 bits (kept in 34): a 32-bit grid plus two 16-bit terms,
  // one of them scaled by the roller number.
  assign speed_up  = {1'b0, in_data_i.trolley_speed} + 17'd7;
  assign lead_d    = speed_up[16:3];
  assign pitch_ofs = 20'(in_data_i.roller) * 20'(cfg_q.roller_length);
  assign base_d    = BASE_W'(in_data_i.target_grid) + BASE_W'(cfg_q.head_length) +
                     BASE_W'(pitch_ofs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_data_i;
      s1_base_q <= base_d;
      s1_lead_q <= lead_d;
    end
  end

  // ---------------- state table ----------------
  assign idx_full = {1'b0, s1_item_q.roller} - 5'd1;
  assign rd_idx   = roller_ok ? idx_full[IdxW-1:0] : '0;
  assign st_rd    = st_q[rd_idx];

  rec_step #(
    .NUM_ROLLERS(NUM_ROLLERS)
  ) u_step (
    .item_i     (s1_item_q),
    .base_i     (s1_base_q),
    .lead_i     (s1_lead_q),
    .st_i       (st_rd),
    .alarm_i    (alarm_q),
    .cfg_i      (cfg_q),
    .roller_ok_o(roller_ok),
    .st_o       (st_d),
    .alarm_o    (alarm_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ROLLERS; i++) begin
        st_q[i] <= '0;
      end
      alarm_q <= '0;
    end else if (s1_fire && roller_ok) begin
      st_q[rd_idx] <= st_d;
      alarm_q      <= alarm_d;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  // A forward drive always leaves the roller waiting in the judge phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && roller_ok && res_d.drive_cmd == CMD_FWD)
      |=> (st_q[$past(rd_idx)].phase == PH_JUDGE))
    else $error("forward drive did not move roller to judge");

  // An outcome is only decided in a step that sends no drive command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.outcome != OUT_NONE)
      |-> (out_data_o.drive_cmd == CMD_NONE))
    else $error("outcome reported together with a drive command");

  // The input side stalls only while a request is held in the input stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a held request");

  // Bit 15 of the alarm word belongs to no roller.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> !alarm_q[15])
    else $error("unused alarm bit set");

  // A request with a bad roller number leaves the alarm word untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !roller_ok) |=> $stable(alarm_q))
    else $error("bad roller request changed the alarm word");

endmodule

@@ bench/tb_roller_eject_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_roller_eject_controller: self-checking bench of the roller eject controller
// Directed requests cover target saturation, the window edges, full eject and
// return sequences, alarms, timer wrap and register masking. Shaped random
// requests then run under several register settings. Both sides idle at random,
// and every result is checked against a predictor of the per-roller phases.
// ----------------------------------------------------------------------------
module tb_roller_eject_controller;
  import rec_pkg::*;

  localparam int unsigned NUM_ROLLERS      = NUM_ROLLERS_DEF;
  localparam int unsigned WATCHDOG_LIMIT   = 3000;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned DRAIN_CYCLES     = 6;

  // Indexes past the last register; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall_o;
  rec_in_t               in_data = '0;
  logic                  out_valid_o;
  logic                  out_stall = 1'b0;
  rec_out_t              out_data_o;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: one entry per roller, entry 0 unused.
  roll_st_t    roller_state [0:15];
  logic [30:0] alarm_model;
  rec_cfg_t    reg_model;

  rec_out_t    pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] ms_now = '0;
  logic        burst_mode = 1'b0;
  logic        hold_now = 1'b0;

  always #6 clk = ~clk;

  roller_eject_controller #(
    .NUM_ROLLERS (NUM_ROLLERS)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Target corrected for roller position and speed lead, clamped to 32 bits.
  function automatic logic [31:0] lead_target(logic [31:0] grid, logic [3:0] roll,
                                              logic [15:0] speed);
    logic [33:0] sum;
    logic [33:0] lead;
    logic [33:0] pitch;
    pitch = {30'd0, roll};
    sum = {2'b00, grid} + {18'd0, reg_model.head_length}
        + pitch * {18'd0, reg_model.roller_length};
    lead = ({18'd0, speed} + 34'd7) >> 3;
    if (sum <= lead) return '0;
    sum = sum - lead;
    if (sum[33:32] != 2'b00) return '1;
    return sum[31:0];
  endfunction

  // Advances the predicted roller state by one request and returns its result.
  function automatic rec_out_t eject_step(rec_in_t req);
    rec_out_t    res;
    roll_st_t    st;
    logic [1:0]  ph;
    logic [31:0] tgt;
    logic [31:0] elapsed;
    int          rot_bit;
    int          ret_bit;
    res = '0;
    res.alarm_word = alarm_model;
    if (req.roller == 4'd0 || req.roller > NUM_ROLLERS) return res;
    st = roller_state[req.roller];
    ph = st.phase;
    rot_bit = int'(req.roller) - 1;
    ret_bit = int'(req.roller) + int'(RET_BIT_OFS);
    case (ph)
      PH_CHECK: begin
        if (req.has_package) begin
          tgt = lead_target(req.target_grid, req.roller, req.trolley_speed);
          if (req.trolley_pos >= tgt &&
              {1'b0, req.trolley_pos} <= {1'b0, tgt} + {25'd0, reg_model.location_window})
            ph = PH_THROW;
        end else if (!req.at_home) begin
          st.attempts = '0;
          ph = PH_BACK;
        end
      end
      PH_THROW: begin
        res.drive_cmd = CMD_FWD;
        st.run_stamp = req.now_ms;
        ph = PH_JUDGE;
      end
      PH_JUDGE: begin
        elapsed = req.now_ms - st.run_stamp;
        if (elapsed >= {16'd0, reg_model.run_time_min}) begin
          if (req.at_home) begin
            res.outcome = OUT_NO_ROT;
            alarm_model[rot_bit] = 1'b1;
            ph = PH_CHECK;
          end else begin
            res.outcome = OUT_EJECTED;
            alarm_model[rot_bit] = 1'b0;
            ph = PH_BACK;
          end
        end
      end
      default: begin
        elapsed = req.now_ms - st.send_stamp;
        if (req.at_home) begin
          ph = PH_CHECK;
          st.attempts = '0;
          alarm_model[ret_bit] = 1'b0;
        end else if (elapsed >= {16'd0, reg_model.retry_interval}) begin
          st.send_stamp = req.now_ms;
          if (st.attempts < reg_model.retry_limit) res.drive_cmd = CMD_BACK;
          else alarm_model[ret_bit] = 1'b1;
          if (st.attempts < ATTEMPT_MAX) st.attempts = st.attempts + 10'd1;
        end
      end
    endcase
    st.phase = ph;
    roller_state[req.roller] = st;
    if (res.drive_cmd != CMD_NONE) begin
      res.drive_roller = req.roller;
      res.drive_direction = req.direction;
    end
    res.alarm_word = alarm_model;
    res.phase_now = ph;
    return res;
  endfunction

  // Builds a request that suits the roller's current phase, so that most
  // requests move the sequence on instead of bouncing off the check phase.
  function automatic rec_in_t shaped_request(logic [3:0] roll);
    rec_in_t     req;
    logic [31:0] tgt;
    req.roller = roll;
    req.has_package = 1'b0;
    req.target_grid = $urandom();
    req.direction = 8'($urandom_range(0, 255));
    req.trolley_pos = $urandom();
    req.trolley_speed = 16'($urandom_range(0, 65535));
    req.at_home = 1'($urandom_range(0, 1));
    req.now_ms = ms_now;
    case (roller_state[roll].phase)
      PH_CHECK: begin
        if ($urandom_range(0, 9) < 7) begin
          req.has_package = 1'b1;
          tgt = lead_target(req.target_grid, roll, req.trolley_speed);
          case ($urandom_range(0, 5))
            0: req.trolley_pos = tgt - 32'd1;
            1: req.trolley_pos = tgt + {24'd0, reg_model.location_window} + 32'd1;
            default: begin
              req.trolley_pos = tgt + $urandom_range(0, reg_model.location_window);
            end
          endcase
        end
      end
      PH_JUDGE: req.at_home = ($urandom_range(0, 3) == 0);
      PH_BACK:  req.at_home = ($urandom_range(0, 7) == 0);
      default: ;
    endcase
    return req;
  endfunction

  function automatic rec_in_t step_req(logic [3:0] roll, logic pkg, logic home,
                                       logic [31:0] grid, logic [31:0] loc,
                                       logic [15:0] speed);
    rec_in_t req;
    req.roller = roll;
    req.has_package = pkg;
    req.target_grid = grid;
    req.direction = 8'($urandom_range(0, 255));
    req.trolley_pos = loc;
    req.trolley_speed = speed;
    req.at_home = home;
    req.now_ms = ms_now;
    return req;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input rec_in_t req);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall_o);
    pending_results.push_back(eject_step(req));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      REG_LOCATION_WINDOW: reg_model.location_window = data[7:0];
      REG_RUN_TIME_MIN:    reg_model.run_time_min = data;
      REG_RETRY_LIMIT:     reg_model.retry_limit = data[9:0];
      REG_RETRY_INTERVAL:  reg_model.retry_interval = data;
      REG_HEAD_LENGTH:     reg_model.head_length = data;
      REG_ROLLER_LENGTH:   reg_model.roller_length = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input rec_cfg_t setting);
    wait_drained();
    write_reg(REG_LOCATION_WINDOW, {8'd0, setting.location_window});
    write_reg(REG_RUN_TIME_MIN, setting.run_time_min);
    write_reg(REG_RETRY_LIMIT, {6'd0, setting.retry_limit});
    write_reg(REG_RETRY_INTERVAL, setting.retry_interval);
    write_reg(REG_HEAD_LENGTH, setting.head_length);
    write_reg(REG_ROLLER_LENGTH, setting.roller_length);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_target_extremes();
    rec_cfg_t setting;
    // Lead larger than the sum clamps the target to zero.
    send_request(step_req(4'd2, 1'b1, 1'b1, 32'd5, 32'd0, 16'hFFFF));
    // Window edges: exactly at the far edge, one past it, one short of target.
    send_request(step_req(4'd4, 1'b1, 1'b1, 32'd1000, 32'd1005, 16'd0));
    send_request(step_req(4'd6, 1'b1, 1'b1, 32'd1000, 32'd1006, 16'd0));
    send_request(step_req(4'd8, 1'b1, 1'b1, 32'd1000, 32'd999, 16'd0));
    // The lead is rounded up: speed 9 gives a lead of 2.
    send_request(step_req(4'd9, 1'b1, 1'b1, 32'd100, 32'd98, 16'd9));
    setting = '{location_window: RST_LOCATION_WINDOW, run_time_min: RST_RUN_TIME_MIN,
                retry_limit: RST_RETRY_LIMIT, retry_interval: RST_RETRY_INTERVAL,
                head_length: 16'hFFFF, roller_length: 16'hFFFF};
    set_config(setting);
    // A sum beyond 32 bits saturates at the top of the range.
    send_request(step_req(4'd14, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0));
    setting.head_length = RST_HEAD_LENGTH;
    setting.roller_length = RST_ROLLER_LENGTH;
    set_config(setting);
  endtask

  task automatic test_eject_cycle();
    ms_now = 32'd1000;
    send_request(step_req(4'd3, 1'b1, 1'b1, 32'd100, 32'd100, 16'd0));
    send_request(step_req(4'd3, 1'b0, 1'b1, 32'd0, 32'd0, 16'd0));
    ms_now = 32'd1499;
    send_request(step_req(4'd3, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0));
    ms_now = 32'd1500;
    send_request(step_req(4'd3, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0));
    send_request(step_req(4'd3, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0));
    ms_now = 32'd1549;
    send_request(step_req(4'd3, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0));
    ms_now = 32'd1550;
    send_request(step_req(4'd3, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0));
    send_request(step_req(4'd3, 1'b0, 1'b1, 32'd0, 32'd0, 16'd0));
  endtask

  task automatic test_no_rotation();
    send_request(step_req(4'd15, 1'b1, 1'b1, 32'd7, 32'd7, 16'd0));
    send_request(step_req(4'd15, 1'b0, 1'b1, 32'd0, 32'd0, 16'd0));
    ms_now = ms_now + 32'd600;
    send_request(step_req(4'd15, 1'b0, 1'b1, 32'd0, 32'd0, 16'd0));
    // A later successful ejection clears the no-rotation flag again.
    send_request(step_req(4'd15, 1'b1, 1'b1, 32'd7, 32'd7, 16'd0));
    send_request(step_req(4'd15, 1'b0, 1'b1, 32'd0, 32'd0, 16'd0));
    ms_now = ms_now + 32'd600;
    send_request(step_req(4'd15, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0));
    send_request(step_req(4'd15, 1'b0, 1'b1, 32'd0, 32'd0, 16'd0));
  endtask

  task automatic test_invalid_roller();
    rec_in_t req;
    req = shaped_request(4'd0);
    req.has_package = 1'b1;
    send_request(req);
  endtask

  task automatic test_config_masking();
    wait_drained();
    write_reg(REG_LOCATION_WINDOW, 16'hFF00);
    write_reg(REG_RETRY_LIMIT, 16'hFC03);
    write_reg(REG_RETRY_INTERVAL, 16'd0);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_request(step_req(4'd10, 1'b1, 1'b1, 32'd500, 32'd501, 16'd0));
    send_request(step_req(4'd10, 1'b1, 1'b1, 32'd500, 32'd500, 16'd0));
  endtask

  task automatic test_retry_limit();
    send_request(step_req(4'd11, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0));
    repeat (5) send_request(step_req(4'd11, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0));
    send_request(step_req(4'd11, 1'b0, 1'b1, 32'd0, 32'd0, 16'd0));
  endtask

  task automatic test_timer_wrap();
    rec_cfg_t setting;
    setting = '{location_window: RST_LOCATION_WINDOW, run_time_min: RST_RUN_TIME_MIN,
                retry_limit: RST_RETRY_LIMIT, retry_interval: RST_RETRY_INTERVAL,
                head_length: RST_HEAD_LENGTH, roller_length: RST_ROLLER_LENGTH};
    set_config(setting);
    ms_now = 32'hFFFF_FF00;
    send_request(step_req(4'd12, 1'b1, 1'b1, 32'd42, 32'd44, 16'd0));
    send_request(step_req(4'd12, 1'b0, 1'b1, 32'd0, 32'd0, 16'd0));
    ms_now = 32'h0000_00F3;
    send_request(step_req(4'd12, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0));
    ms_now = 32'h0000_00F4;
    send_request(step_req(4'd12, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0));
    send_request(step_req(4'd12, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0));
    send_request(step_req(4'd12, 1'b0, 1'b1, 32'd0, 32'd0, 16'd0));
  endtask

  // Past the limit the attempt count has to hold at its maximum; a wrap
  // would make backward drives reappear.
  task automatic test_attempt_saturation();
    rec_cfg_t setting;
    setting = '{location_window: RST_LOCATION_WINDOW, run_time_min: RST_RUN_TIME_MIN,
                retry_limit: 10'd1023, retry_interval: 16'd0,
                head_length: RST_HEAD_LENGTH, roller_length: RST_ROLLER_LENGTH};
    set_config(setting);
    send_request(step_req(4'd7, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0));
    repeat (1026) send_request(step_req(4'd7, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0));
    send_request(step_req(4'd7, 1'b0, 1'b1, 32'd0, 32'd0, 16'd0));
  endtask

  task automatic test_back_pressure();
    rec_in_t req;
    burst_mode = 1'b1;
    hold_now = 1'b1;
    for (int i = 0; i < 40; i++) begin
      req = shaped_request(4'($urandom_range(1, NUM_ROLLERS)));
      send_request(req);
      ms_now = ms_now + $urandom_range(0, 60);
    end
    burst_mode = 1'b0;
  endtask

  task automatic run_random_phase(input rec_cfg_t setting, input int unsigned n_items,
                                  input int unsigned step_max);
    rec_in_t    req;
    logic [3:0] roll;
    set_config(setting);
    roll = 4'd1;
    for (int i = 0; i < n_items; i++) begin
      if (i % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) >= 3) roll = 4'($urandom_range(1, NUM_ROLLERS));
      if ($urandom_range(0, 9) == 0) begin
        // Noise: any roller, any switch state, any time stamp.
        req = shaped_request(4'($urandom_range(0, 15)));
        req.has_package = 1'($urandom_range(0, 1));
        req.trolley_pos = $urandom();
        req.now_ms = $urandom();
      end else begin
        req = shaped_request(roll);
      end
      send_request(req);
      ms_now = ms_now + $urandom_range(0, step_max);
    end
    burst_mode = 1'b0;
  endtask

  task automatic test_random_settings();
    rec_cfg_t setting;
    setting = '{location_window: RST_LOCATION_WINDOW, run_time_min: RST_RUN_TIME_MIN,
                retry_limit: RST_RETRY_LIMIT, retry_interval: RST_RETRY_INTERVAL,
                head_length: RST_HEAD_LENGTH, roller_length: RST_ROLLER_LENGTH};
    run_random_phase(setting, 20, 40);
    setting = '0;
    run_random_phase(setting, 20, 3);
    setting = '{location_window: 8'hFF, run_time_min: 16'hFFFF, retry_limit: 10'h3FF,
                retry_interval: 16'hFFFF, head_length: 16'hFFFF, roller_length: 16'hFFFF};
    run_random_phase(setting, 20, 8000);
    setting = '{location_window: 8'($urandom_range(0, 255)),
                run_time_min: 16'($urandom_range(0, 2000)),
                retry_limit: 10'($urandom_range(0, 20)),
                retry_interval: 16'($urandom_range(0, 300)),
                head_length: 16'($urandom_range(0, 65535)),
                roller_length: 16'($urandom_range(0, 65535))};
    run_random_phase(setting, 20, 100);
  endtask

  // Result side: a random hold-off before each result, or one long hold.
  initial begin : result_sink
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk);
      if (hold_now) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_now = 1'b0;
        out_stall <= 1'b0;
      end else begin
        hold = burst_mode ? 0 : $urandom_range(0, 3);
        if (hold != 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(negedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk); while (!out_valid_o);
      end
    end
  end

  always @(posedge clk) begin : result_check
    rec_out_t want;
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
          (cfg_valid && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else if (out_valid_o && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: %p", out_data_o);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.drive_cmd !== want.drive_cmd) begin
            $error("drive_cmd: expected %0d, got %0d", want.drive_cmd, out_data_o.drive_cmd);
            mismatch_count++;
          end
          if (out_data_o.drive_roller !== want.drive_roller) begin
            $error("drive_roller: expected %0d, got %0d",
                   want.drive_roller, out_data_o.drive_roller);
            mismatch_count++;
          end
          if (out_data_o.drive_direction !== want.drive_direction) begin
            $error("drive_direction: expected %0d, got %0d",
                   want.drive_direction, out_data_o.drive_direction);
            mismatch_count++;
          end
          if (out_data_o.outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, out_data_o.outcome);
            mismatch_count++;
          end
          if (out_data_o.alarm_word !== want.alarm_word) begin
            $error("alarm_word: expected %h, got %h", want.alarm_word, out_data_o.alarm_word);
            mismatch_count++;
          end
          if (out_data_o.phase_now !== want.phase_now) begin
            $error("phase_now: expected %0d, got %0d", want.phase_now, out_data_o.phase_now);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin : main_sequence
    for (int i = 0; i < 16; i++) roller_state[i] = '0;
    alarm_model = '0;
    reg_model = '{location_window: RST_LOCATION_WINDOW, run_time_min: RST_RUN_TIME_MIN,
                  retry_limit: RST_RETRY_LIMIT, retry_interval: RST_RETRY_INTERVAL,
                  head_length: RST_HEAD_LENGTH, roller_length: RST_ROLLER_LENGTH};
    ms_now = $urandom();
    repeat (4) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    test_target_extremes();
    test_eject_cycle();
    test_no_rotation();
    test_invalid_roller();
    test_config_masking();
    test_retry_limit();
    test_timer_wrap();
    test_attempt_saturation();
    test_back_pressure();
    test_random_settings();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/rec_pkg.sv
src/rec_step.sv
src/roller_eject_controller.sv
bench/tb_roller_eject_controller.sv
